### src/risc_integer_alu_execute_unit_defines.svh
// assertion macros shared by the execute unit rtl
`ifndef RISC_INTEGER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define RISC_INTEGER_ALU_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define RIALU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rialu check failed");
// next-cycle implication, checked out of reset
`define RIALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rialu check failed");
`else
`define RIALU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RIALU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/rialu_pkg.sv
// shared types and constants of the integer execute unit
package rialu_pkg;

	localparam int RegCount = 32;
	localparam int RegIdxW  = $clog2(RegCount);
	localparam int DataW    = 32;
	localparam int ImmW     = 16;
	localparam int CmdW     = 5;

	// operation codes
	typedef enum logic [CmdW-1:0] {
		CMD_SLL   = 5'd0,
		CMD_SRL   = 5'd1,
		CMD_SRA   = 5'd2,
		CMD_SLLV  = 5'd3,
		CMD_SRLV  = 5'd4,
		CMD_SRAV  = 5'd5,
		CMD_MFHI  = 5'd6,
		CMD_MTHI  = 5'd7,
		CMD_MFLO  = 5'd8,
		CMD_MTLO  = 5'd9,
		CMD_ADDU  = 5'd10,
		CMD_SUBU  = 5'd11,
		CMD_AND   = 5'd12,
		CMD_OR    = 5'd13,
		CMD_XOR   = 5'd14,
		CMD_NOR   = 5'd15,
		CMD_SLT   = 5'd16,
		CMD_SLTU  = 5'd17,
		CMD_ADDIU = 5'd18,
		CMD_ANDI  = 5'd19,
		CMD_ORI   = 5'd20,
		CMD_XORI  = 5'd21,
		CMD_LUI   = 5'd22,
		CMD_SLTI  = 5'd23,
		CMD_SLTIU = 5'd24
	} cmd_t;

	// destination kinds
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GPR  = 2'd1,
		KIND_HI   = 2'd2,
		KIND_LO   = 2'd3
	} kind_t;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef struct packed {
		logic [CmdW-1:0]    cmd;
		logic [RegIdxW-1:0] dest_reg;
		logic [RegIdxW-1:0] source_reg;
		logic [RegIdxW-1:0] target_reg;
		logic [4:0]         shift_amount;
		logic [ImmW-1:0]    immediate;
	} item_t;

	typedef struct packed {
		kind_t              dest_kind;
		logic [RegIdxW-1:0] dest_index;
		logic [DataW-1:0]   write_value;
		logic               status;
	} result_t;

endpackage

### src/rialu_if.sv
// handshake channels for instruction items and result items
interface rialu_issue_if import rialu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CmdW-1:0]     cmd;
	logic [RegIdxW-1:0]  dest_reg;
	logic [RegIdxW-1:0]  source_reg;
	logic [RegIdxW-1:0]  target_reg;
	logic [4:0]          shift_amount;
	logic [ImmW-1:0]     immediate;

	modport source (output valid, cmd, dest_reg, source_reg, target_reg, shift_amount,
		immediate, input ready);
	modport sink (input valid, cmd, dest_reg, source_reg, target_reg, shift_amount,
		immediate, output ready);
endinterface

interface rialu_result_if import rialu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          dest_kind;
	logic [RegIdxW-1:0]  dest_index;
	logic [DataW-1:0]    write_value;
	logic                status;

	modport source (output valid, dest_kind, dest_index, write_value, status, input ready);
	modport sink (input valid, dest_kind, dest_index, write_value, status, output ready);
endinterface

### src/rialu_ram.sv
// generic single-write single-read ram with registered read data
module rialu_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/rialu_alu.sv
// operation decode and datapath for one instruction item
module rialu_alu import rialu_pkg::*; (
	input  item_t             item,
	input  logic [DataW-1:0]  rs_val,
	input  logic [DataW-1:0]  rt_val,
	input  logic [DataW-1:0]  hi_val,
	input  logic [DataW-1:0]  lo_val,
	output result_t           res
);

	logic [DataW-1:0] imm_zx;
	logic [DataW-1:0] imm_sx;
	logic [4:0]       var_sh;
	logic [DataW-1:0] value;
	kind_t            kind;
	logic [RegIdxW-1:0] index;
	logic             reject;

	// immediate forms and variable shift count
	assign imm_zx = {{(DataW-ImmW){1'b0}}, item.immediate};
	assign imm_sx = {{(DataW-ImmW){item.immediate[ImmW-1]}}, item.immediate};
	assign var_sh = rs_val[4:0];

	// operation decode
	always_comb begin
		value  = '0;
		kind   = KIND_GPR;
		index  = item.dest_reg;
		reject = 1'b0;
		unique case (cmd_t'(item.cmd))
			CMD_SLL:   value = rt_val << item.shift_amount;
			CMD_SRL:   value = rt_val >> item.shift_amount;
			CMD_SRA:   value = DataW'($signed(rt_val) >>> item.shift_amount);
			CMD_SLLV:  value = rt_val << var_sh;
			CMD_SRLV:  value = rt_val >> var_sh;
			CMD_SRAV:  value = DataW'($signed(rt_val) >>> var_sh);
			CMD_MFHI:  value = hi_val;
			CMD_MTHI: begin
				value = rs_val;
				kind  = KIND_HI;
			end
			CMD_MFLO:  value = lo_val;
			CMD_MTLO: begin
				value = rs_val;
				kind  = KIND_LO;
			end
			CMD_ADDU:  value = rs_val + rt_val;
			CMD_SUBU:  value = rs_val - rt_val;
			CMD_AND:   value = rs_val & rt_val;
			CMD_OR:    value = rs_val | rt_val;
			CMD_XOR:   value = rs_val ^ rt_val;
			CMD_NOR:   value = ~(rs_val | rt_val);
			CMD_SLT:   value = DataW'($signed(rs_val) < $signed(rt_val));
			CMD_SLTU:  value = DataW'(rs_val < rt_val);
			CMD_ADDIU: begin
				value = rs_val + imm_sx;
				index = item.target_reg;
			end
			CMD_ANDI: begin
				value = rs_val & imm_zx;
				index = item.target_reg;
			end
			CMD_ORI: begin
				value = rs_val | imm_zx;
				index = item.target_reg;
			end
			CMD_XORI: begin
				value = rs_val ^ imm_zx;
				index = item.target_reg;
			end
			CMD_LUI: begin
				value = {item.immediate, {(DataW-ImmW){1'b0}}};
				index = item.target_reg;
			end
			CMD_SLTI: begin
				value = DataW'($signed(rs_val) < $signed(imm_sx));
				index = item.target_reg;
			end
			CMD_SLTIU: begin
				value = DataW'(rs_val < imm_sx);
				index = item.target_reg;
			end
			default:   reject = 1'b1;
		endcase
	end

	// final result: rejects and writes to register zero report nothing written
	always_comb begin
		res.status      = STATUS_OK;
		res.dest_kind   = kind;
		res.dest_index  = '0;
		res.write_value = value;
		if (reject) begin
			res.status      = STATUS_REJECTED;
			res.dest_kind   = KIND_NONE;
			res.write_value = '0;
		end else if (kind == KIND_GPR) begin
			if (index == '0) begin
				res.dest_kind   = KIND_NONE;
				res.write_value = '0;
			end else begin
				res.dest_index = index;
			end
		end
	end

endmodule

### src/risc_integer_alu_execute_unit.sv
// Integer execute unit: takes one decoded instruction item per clock and returns one result
// item for each, in order. An accepted item sits in the input stage while the two register
// file ports deliver its operands, then its result is computed and latched in the result
// register, from which it is offered; with the result side ready the unit sustains one
// item per cycle. The register file is two copies of a 32-entry ram with registered read,
// addressed at acceptance; the last register write is forwarded so back-to-back dependent
// instructions see it. Per-entry valid bits make the file read as zero after reset, so no
// clearing pass is needed. HI and LO are flip-flops.
`include "risc_integer_alu_execute_unit_defines.svh"

module risc_integer_alu_execute_unit import rialu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rialu_issue_if.sink           issue,
	rialu_result_if.source        result
);

	item_t               item_s1;
	logic                valid_s1;
	result_t             result_q;
	logic                out_valid_q;
	logic [RegCount-1:0] rf_valid_q;
	logic                wb_en_q;
	logic [RegIdxW-1:0]  wb_idx_q;
	logic [DataW-1:0]    wb_val_q;
	logic [DataW-1:0]    hi_q;
	logic [DataW-1:0]    lo_q;
	logic [DataW-1:0]    ram_rs;
	logic [DataW-1:0]    ram_rt;
	logic [DataW-1:0]    rs_val;
	logic [DataW-1:0]    rt_val;
	result_t             alu_res;
	logic                advance;
	logic                accept;
	logic                gpr_we;

	// handshake control
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign issue.ready = !valid_s1 || advance;
	assign accept      = issue.valid && issue.ready;
	assign gpr_we      = advance && (alu_res.dest_kind == KIND_GPR);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue.ready) begin
			valid_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd          <= issue.cmd;
			item_s1.dest_reg     <= issue.dest_reg;
			item_s1.source_reg   <= issue.source_reg;
			item_s1.target_reg   <= issue.target_reg;
			item_s1.shift_amount <= issue.shift_amount;
			item_s1.immediate    <= issue.immediate;
		end
	end

	// register file, one copy per read port
	rialu_ram #(.Width(DataW), .Depth(RegCount)) u_rf_rs (
		.clk   (clk),
		.we    (gpr_we),
		.waddr (alu_res.dest_index),
		.wdata (alu_res.write_value),
		.re    (accept),
		.raddr (issue.source_reg),
		.rdata (ram_rs)
	);

	rialu_ram #(.Width(DataW), .Depth(RegCount)) u_rf_rt (
		.clk   (clk),
		.we    (gpr_we),
		.waddr (alu_res.dest_index),
		.wdata (alu_res.write_value),
		.re    (accept),
		.raddr (issue.target_reg),
		.rdata (ram_rt)
	);

	// valid bits and last-write forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			wb_en_q    <= 1'b0;
		end else if (gpr_we) begin
			rf_valid_q[alu_res.dest_index] <= 1'b1;
			wb_en_q                        <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (gpr_we) begin
			wb_idx_q <= alu_res.dest_index;
			wb_val_q <= alu_res.write_value;
		end
	end

	// operand select: zero register, forwarded write, stored entry, reset value
	always_comb begin
		if (item_s1.source_reg == '0) begin
			rs_val = '0;
		end else if (wb_en_q && (wb_idx_q == item_s1.source_reg)) begin
			rs_val = wb_val_q;
		end else if (rf_valid_q[item_s1.source_reg]) begin
			rs_val = ram_rs;
		end else begin
			rs_val = '0;
		end
	end

	always_comb begin
		if (item_s1.target_reg == '0) begin
			rt_val = '0;
		end else if (wb_en_q && (wb_idx_q == item_s1.target_reg)) begin
			rt_val = wb_val_q;
		end else if (rf_valid_q[item_s1.target_reg]) begin
			rt_val = ram_rt;
		end else begin
			rt_val = '0;
		end
	end

	// execute
	rialu_alu u_alu (
		.item   (item_s1),
		.rs_val (rs_val),
		.rt_val (rt_val),
		.hi_val (hi_q),
		.lo_val (lo_q),
		.res    (alu_res)
	);

	// hi and lo registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (advance) begin
			if (alu_res.dest_kind == KIND_HI) begin
				hi_q <= alu_res.write_value;
			end
			if (alu_res.dest_kind == KIND_LO) begin
				lo_q <= alu_res.write_value;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= alu_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.dest_kind   = result_q.dest_kind;
	assign result.dest_index  = result_q.dest_index;
	assign result.write_value = result_q.write_value;
	assign result.status      = result_q.status;

	// checks
	`RIALU_ASSERT_NOW(a_no_zero_write, clk, arst_n, gpr_we, alu_res.dest_index != '0)
	`RIALU_ASSERT_NOW(a_reject_clean, clk, arst_n,
		out_valid_q && (result_q.status == STATUS_REJECTED),
		(result_q.dest_kind == KIND_NONE) && (result_q.write_value == '0))
	`RIALU_ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q)
	`RIALU_ASSERT_NEXT(a_hi_only_by_mthi, clk, arst_n,
		!(advance && (alu_res.dest_kind == KIND_HI)), $stable(hi_q))
	`RIALU_ASSERT_NOW(a_stall_reason, clk, arst_n, !issue.ready,
		valid_s1 && out_valid_q && !result.ready)

endmodule

### test/tb_top.sv
// testbench for the integer execute unit: self-predicting stimulus with in-order result checks
module tb_top import rialu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 200000;
	localparam int ReportLimit = 10;
	localparam int DrainMargin = 10;
	localparam int MixItems    = 700;
	localparam int ChainItems  = 420;
	localparam int CmdTop      = (1 << CmdW) - 1;

	logic clk;
	logic arst_n;

	rialu_issue_if  issue_bus ();
	rialu_result_if result_bus ();

	risc_integer_alu_execute_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue_bus),
		.result (result_bus)
	);

	// architectural state as the checker sees it
	logic [DataW-1:0] gpr_shadow [RegCount] = '{default: '0};
	logic [DataW-1:0] hi_shadow = '0;
	logic [DataW-1:0] lo_shadow = '0;

	result_t pending_results [$];
	int      cycle_count = 0;
	int      fail_count = 0;
	int      items_sent = 0;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side back-pressure, cycling through four styles as the cycle count grows
	always @(negedge clk) begin
		case ((cycle_count >> 8) & 3)
			0: begin
				result_bus.ready <= 1'b1;
			end
			1: begin
				result_bus.ready <= (cycle_count % 5) != 0;
			end
			2: begin
				result_bus.ready <= $urandom_range(0, 3) != 0;
			end
			default: begin
				result_bus.ready <= (cycle_count % 9) >= 4;
			end
		endcase
	end

	// execute one instruction against the shadow state, return the write it makes
	function automatic result_t execute_instr(input item_t it);
		logic [DataW-1:0]   rs_val;
		logic [DataW-1:0]   rt_val;
		logic [DataW-1:0]   imm_sx;
		logic [DataW-1:0]   imm_zx;
		logic [DataW-1:0]   value;
		logic [RegIdxW-1:0] idx;
		kind_t              kind;
		result_t            res;
		rs_val = (it.source_reg == '0) ? '0 : gpr_shadow[it.source_reg];
		rt_val = (it.target_reg == '0) ? '0 : gpr_shadow[it.target_reg];
		imm_sx = {{(DataW-ImmW){it.immediate[ImmW-1]}}, it.immediate};
		imm_zx = {{(DataW-ImmW){1'b0}}, it.immediate};
		kind = KIND_GPR;
		idx = it.dest_reg;
		value = '0;
		case (it.cmd)
			CMD_SLL:   value = rt_val << it.shift_amount;
			CMD_SRL:   value = rt_val >> it.shift_amount;
			CMD_SRA:   value = $signed(rt_val) >>> it.shift_amount;
			CMD_SLLV:  value = rt_val << rs_val[4:0];
			CMD_SRLV:  value = rt_val >> rs_val[4:0];
			CMD_SRAV:  value = $signed(rt_val) >>> rs_val[4:0];
			CMD_MFHI:  value = hi_shadow;
			CMD_MTHI: begin
				value = rs_val;
				kind = KIND_HI;
			end
			CMD_MFLO:  value = lo_shadow;
			CMD_MTLO: begin
				value = rs_val;
				kind = KIND_LO;
			end
			CMD_ADDU:  value = rs_val + rt_val;
			CMD_SUBU:  value = rs_val - rt_val;
			CMD_AND:   value = rs_val & rt_val;
			CMD_OR:    value = rs_val | rt_val;
			CMD_XOR:   value = rs_val ^ rt_val;
			CMD_NOR:   value = ~(rs_val | rt_val);
			CMD_SLT:   value = {31'b0, $signed(rs_val) < $signed(rt_val)};
			CMD_SLTU:  value = {31'b0, rs_val < rt_val};
			CMD_ADDIU: value = rs_val + imm_sx;
			CMD_ANDI:  value = rs_val & imm_zx;
			CMD_ORI:   value = rs_val | imm_zx;
			CMD_XORI:  value = rs_val ^ imm_zx;
			CMD_LUI:   value = {it.immediate, 16'b0};
			CMD_SLTI:  value = {31'b0, $signed(rs_val) < $signed(imm_sx)};
			CMD_SLTIU: value = {31'b0, rs_val < imm_sx};
			default: begin
				// unsupported: no state change, only the reject flag
				res.dest_kind = KIND_NONE;
				res.dest_index = '0;
				res.write_value = '0;
				res.status = STATUS_REJECTED;
				return res;
			end
		endcase
		// immediate forms write rt
		if (it.cmd >= CMD_ADDIU)
			idx = it.target_reg;
		if (kind == KIND_GPR) begin
			if (idx == '0) begin
				kind = KIND_NONE;
				value = '0;
			end else begin
				gpr_shadow[idx] = value;
			end
		end else begin
			idx = '0;
			if (kind == KIND_HI)
				hi_shadow = value;
			else
				lo_shadow = value;
		end
		res.dest_kind = kind;
		res.dest_index = idx;
		res.write_value = value;
		res.status = STATUS_OK;
		return res;
	endfunction

	// predict on every accepted item, compare every accepted result
	always @(posedge clk) begin
		item_t   seen;
		result_t want;
		if (arst_n) begin
			if (issue_bus.valid && issue_bus.ready) begin
				seen.cmd = issue_bus.cmd;
				seen.dest_reg = issue_bus.dest_reg;
				seen.source_reg = issue_bus.source_reg;
				seen.target_reg = issue_bus.target_reg;
				seen.shift_amount = issue_bus.shift_amount;
				seen.immediate = issue_bus.immediate;
				pending_results.insert(pending_results.size(), execute_instr(seen));
			end
			if (result_bus.valid && result_bus.ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= ReportLimit)
						$display("unexpected result item: kind %0d idx %0d value %h status %0b",
							result_bus.dest_kind, result_bus.dest_index,
							result_bus.write_value, result_bus.status);
				end else begin
					want = pending_results.pop_front();
					if (result_bus.dest_kind !== want.dest_kind ||
						result_bus.dest_index !== want.dest_index ||
						result_bus.write_value !== want.write_value ||
						result_bus.status !== want.status) begin
						fail_count++;
						if (fail_count <= ReportLimit)
							$display("mismatch at cycle %0d: exp kind %0d idx %0d value %h st %0b,%s",
								cycle_count, want.dest_kind, want.dest_index,
								want.write_value, want.status, " got");
						if (fail_count <= ReportLimit)
							$display("  got kind %0d idx %0d value %h st %0b",
								result_bus.dest_kind, result_bus.dest_index,
								result_bus.write_value, result_bus.status);
					end
				end
			end
		end
	end

	function automatic item_t make_item(input logic [CmdW-1:0] cmd,
		input logic [RegIdxW-1:0] rd, input logic [RegIdxW-1:0] rs,
		input logic [RegIdxW-1:0] rt, input logic [4:0] sa, input logic [ImmW-1:0] imm);
		item_t it;
		it.cmd = cmd;
		it.dest_reg = rd;
		it.source_reg = rs;
		it.target_reg = rt;
		it.shift_amount = sa;
		it.immediate = imm;
		return it;
	endfunction

	// register index, biased toward a small pool so values get reused
	function automatic logic [RegIdxW-1:0] pick_reg();
		return RegIdxW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) :
			$urandom_range(0, 31));
	endfunction

	// immediate, with the sign boundary and extremes favored
	function automatic logic [ImmW-1:0] pick_imm();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return ImmW'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic item_t random_instr();
		item_t it;
		int    roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			it.cmd = CmdW'($urandom_range(CMD_SLTIU + 1, CmdTop));
		else if (roll < 20)
			it.cmd = ($urandom_range(0, 1) == 0) ? CMD_LUI : CMD_ORI;
		else
			it.cmd = CmdW'($urandom_range(CMD_SLL, CMD_SLTIU));
		it.dest_reg = RegIdxW'($urandom_range(0, 31));
		it.source_reg = pick_reg();
		it.target_reg = pick_reg();
		it.shift_amount = 5'($urandom_range(0, 31));
		it.immediate = pick_imm();
		return it;
	endfunction

	// present one item and hold it until accepted; returns at a falling edge
	task automatic send_item(input item_t it);
		issue_bus.valid <= 1'b1;
		issue_bus.cmd <= it.cmd;
		issue_bus.dest_reg <= it.dest_reg;
		issue_bus.source_reg <= it.source_reg;
		issue_bus.target_reg <= it.target_reg;
		issue_bus.shift_amount <= it.shift_amount;
		issue_bus.immediate <= it.immediate;
		do @(posedge clk); while (!issue_bus.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			issue_bus.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop sending until every outstanding result has come back
	task automatic wait_results_done();
		issue_bus.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// every operation at least once, field extremes, register zero and rejects, back to back
	task automatic test_directed_ops();
		send_item(make_item(CMD_LUI,   0, 0, 1, 0, 16'hFFFF));
		send_item(make_item(CMD_ORI,   0, 1, 1, 0, 16'hFFFF));
		send_item(make_item(CMD_ADDIU, 0, 0, 2, 0, 16'h8000));
		send_item(make_item(CMD_ADDIU, 0, 0, 3, 0, 16'h7FFF));
		send_item(make_item(CMD_SLL,   4, 0, 1, 31, 16'h0));
		send_item(make_item(CMD_SRL,   5, 0, 1, 31, 16'h0));
		send_item(make_item(CMD_SRA,   6, 0, 4, 31, 16'h0));
		send_item(make_item(CMD_SLLV,  7, 3, 1, 0, 16'h0));
		send_item(make_item(CMD_SRLV,  8, 3, 2, 0, 16'h0));
		send_item(make_item(CMD_SRAV,  9, 1, 2, 0, 16'h0));
		send_item(make_item(CMD_MTHI,  0, 1, 0, 0, 16'h0));
		send_item(make_item(CMD_MTLO,  0, 3, 0, 0, 16'h0));
		send_item(make_item(CMD_MFHI, 10, 0, 0, 0, 16'h0));
		send_item(make_item(CMD_MFLO, 31, 0, 0, 0, 16'h0));
		send_item(make_item(CMD_ADDU, 11, 1, 1, 0, 16'h0));
		send_item(make_item(CMD_SUBU, 12, 0, 1, 0, 16'h0));
		send_item(make_item(CMD_AND,  13, 1, 2, 0, 16'h0));
		send_item(make_item(CMD_OR,   14, 2, 3, 0, 16'h0));
		send_item(make_item(CMD_XOR,  15, 1, 3, 0, 16'h0));
		// nor into register zero: nothing stored
		send_item(make_item(CMD_NOR,   0, 0, 0, 0, 16'h0));
		send_item(make_item(CMD_SLT,  16, 1, 3, 0, 16'h0));
		send_item(make_item(CMD_SLTU, 17, 1, 3, 0, 16'h0));
		send_item(make_item(CMD_ANDI,  0, 1, 18, 0, 16'h8000));
		send_item(make_item(CMD_XORI,  0, 1, 19, 0, 16'hFFFF));
		send_item(make_item(CMD_SLTI,  0, 2, 20, 0, 16'hFFFF));
		send_item(make_item(CMD_SLTIU, 0, 3, 21, 0, 16'h8000));
		// unsupported codes at both ends of the unused range
		send_item(make_item(CmdW'(CMD_SLTIU + 1), 31, 31, 31, 31, 16'hFFFF));
		send_item(make_item(CmdW'(CmdTop), 1, 1, 1, 0, 16'h0));
		wait_results_done();
	endtask

	// random instructions in bursts, with full drains now and then
	task automatic test_random_mix();
		int done;
		int burst;
		done = 0;
		while (done < MixItems) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_item(random_instr());
				done++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
			if ($urandom_range(0, 29) == 0)
				wait_results_done();
		end
	endtask

	// back-to-back chains where each item reads the register most recently written in the chain
	task automatic test_dependent_chains();
		item_t              it;
		logic [RegIdxW-1:0] last_dest;
		int                 done;
		int                 len;
		done = 0;
		while (done < ChainItems) begin
			len = $urandom_range(4, 12);
			last_dest = RegIdxW'($urandom_range(1, 31));
			repeat (len) begin
				it = random_instr();
				it.source_reg = last_dest;
				if ($urandom_range(0, 1) == 0 && it.cmd < CMD_ADDIU)
					it.target_reg = last_dest;
				send_item(it);
				done++;
				if (it.cmd >= CMD_ADDIU && it.cmd <= CMD_SLTIU)
					last_dest = it.target_reg;
				else if (it.cmd <= CMD_SLTU && it.cmd != CMD_MTHI && it.cmd != CMD_MTLO)
					last_dest = it.dest_reg;
			end
			idle_cycles($urandom_range(0, 4));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		issue_bus.valid = 1'b0;
		issue_bus.cmd = '0;
		issue_bus.dest_reg = '0;
		issue_bus.source_reg = '0;
		issue_bus.target_reg = '0;
		issue_bus.shift_amount = '0;
		issue_bus.immediate = '0;
		result_bus.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_random_mix();
		test_dependent_chains();

		wait_results_done();
		repeat (DrainMargin) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/rialu_pkg.sv
src/rialu_if.sv
src/rialu_ram.sv
src/rialu_alu.sv
src/risc_integer_alu_execute_unit.sv
test/tb_top.sv
